// File: design/fir_linear_convolution_core_defines.svh
// ---------------------------------------------------------------------------
// FIR core assertion macros
// Implication checks sampled on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef FIR_LINEAR_CONVOLUTION_CORE_DEFINES_SVH
`define FIR_LINEAR_CONVOLUTION_CORE_DEFINES_SVH

// same-cycle implication
`define FLC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FLC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: design/flc_pkg.sv
// ---------------------------------------------------------------------------
// FIR core package
// Field widths, command codes and controller/datapath link types.
// ---------------------------------------------------------------------------
package flc_pkg;

    localparam int MAX_TAPS_DEF = 64;
    localparam int CMD_W        = 2;
    localparam int IDX_W        = 6;
    localparam int VAL_W        = 16;
    localparam int PROD_W       = 2 * VAL_W;
    localparam int OUT_W        = 48;
    localparam int TAPC_W       = 7;

    localparam logic [TAPC_W-1:0] TAP_COUNT_RST = TAPC_W'(64);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_PUSH  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef struct packed {
        logic load_coef;
        logic clear_hist;
        logic push;
        logic issue;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic last_tap;
        logic pipe_busy;
    } t_dp_sts;

endpackage

// File: design/flc_if.sv
// ---------------------------------------------------------------------------
// FIR core channels
// Input word, result word and configuration write channels.
// ---------------------------------------------------------------------------
interface flc_in_if import flc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic        [CMD_W-1:0] cmd;
    logic        [IDX_W-1:0] tap_index;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output cmd, output tap_index, output value, input ready);
    modport sink   (input valid, input cmd, input tap_index, input value, output ready);
endinterface

interface flc_out_if import flc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

interface flc_cfg_if import flc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TAPC_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/flc_datapath.sv
// ---------------------------------------------------------------------------
// FIR core datapath
// Tap and delay-line memories, shared multiply-accumulate, result register.
// ---------------------------------------------------------------------------
module flc_datapath import flc_pkg::*; #(
    parameter int MAX_TAPS = MAX_TAPS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [TAPC_W-1:0]       i_cfg_data,
    input  logic [IDX_W-1:0]        i_tap_index,
    input  logic signed [VAL_W-1:0] i_value,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    output logic signed [OUT_W-1:0] o_filtered
);

    localparam int AW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNTW = $clog2(MAX_TAPS + 1);

    logic signed [VAL_W-1:0] coef_mem [MAX_TAPS];
    logic signed [VAL_W-1:0] hist_mem [MAX_TAPS];

    logic [TAPC_W-1:0]        r_tap_count;
    logic [AW-1:0]            r_head, n_head;
    logic [CNTW-1:0]          r_fill, n_fill;
    logic [AW-1:0]            r_j;
    logic [AW-1:0]            r_slot, n_slot;
    logic signed [VAL_W-1:0]  r_coef_q;
    logic signed [VAL_W-1:0]  r_hist_q;
    logic                     r_live_q;
    logic                     r_v1;
    logic                     r_v2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [OUT_W-1:0]  r_acc;
    logic signed [OUT_W-1:0]  r_out;
    logic [CNTW-1:0]          taps;

    always_comb begin
        if (r_tap_count == '0) begin
            taps = CNTW'(1);
        end else if (int'(r_tap_count) > MAX_TAPS) begin
            taps = CNTW'(MAX_TAPS);
        end else begin
            taps = CNTW'(r_tap_count);
        end
        n_head = (r_head == AW'(MAX_TAPS - 1)) ? '0 : r_head + AW'(1);
        n_fill = (r_fill == CNTW'(MAX_TAPS)) ? r_fill : r_fill + CNTW'(1);
        n_slot = (r_slot == '0) ? AW'(MAX_TAPS - 1) : r_slot - AW'(1);
    end

    assign o_sts.last_tap  = (CNTW'(r_j) == taps - CNTW'(1));
    assign o_sts.pipe_busy = r_v1 | r_v2;
    assign o_filtered      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_COUNT_RST;
            r_head      <= '0;
            r_fill      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tap_count <= i_cfg_data;
            end
            if (i_cmd.clear_hist) begin
                r_head <= '0;
                r_fill <= '0;
            end else if (i_cmd.push) begin
                r_head <= n_head;
                r_fill <= n_fill;
            end
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_coef && (int'(i_tap_index) < MAX_TAPS)) begin
            coef_mem[AW'(i_tap_index)] <= i_value;
        end
        if (i_cmd.push) begin
            hist_mem[r_head] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_j    <= '0;
            r_slot <= r_head;
        end else if (i_cmd.issue) begin
            r_j    <= r_j + AW'(1);
            r_slot <= n_slot;
        end
        if (i_cmd.issue) begin
            r_coef_q <= coef_mem[r_j];
            r_hist_q <= hist_mem[r_slot];
            r_live_q <= (CNTW'(r_j) < r_fill);
        end
        if (r_v1) begin
            if (r_live_q) begin
                r_prod <= r_coef_q * r_hist_q;
            end else begin
                r_prod <= '0;
            end
        end
        if (i_cmd.push) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + OUT_W'(r_prod);
        end
        if (i_cmd.out_load) begin
            r_out <= r_acc;
        end
    end

endmodule

// File: design/flc_ctrl.sv
// ---------------------------------------------------------------------------
// FIR core controller
// Word decode, tap sequencing and result handshake.
// ---------------------------------------------------------------------------
module flc_ctrl import flc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_in_cmd,
    input  logic             i_out_ready,
    input  t_dp_sts          i_sts,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output t_dp_cmd          o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_cmd'(i_in_cmd))
                        CMD_LOAD:  o_cmd.load_coef  = 1'b1;
                        CMD_CLEAR: o_cmd.clear_hist = 1'b1;
                        CMD_PUSH: begin
                            o_cmd.push = 1'b1;
                            n_state    = S_MAC;
                        end
                        default: ;
                    endcase
                end
            end
            S_MAC: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_tap) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy && (!r_out_valid || i_out_ready)) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: design/fir_linear_convolution_core.sv
// ---------------------------------------------------------------------------
// Direct-form FIR convolution core
// Loads taps, pushes Q1.15 samples through a delay line and returns the
// full-precision Q18.30 sum over the active taps.
//
//   channel    dir  payload                        handshake
//   i_in_ch    in   cmd[1:0] tap_index[5:0] value  valid/ready
//   o_out_ch   out  filtered[47:0]                 valid/ready
//   i_cfg_ch   in   data[6:0] (tap_count)          valid/ready, ready tied high
//
// Load, clear and unused words are taken while idle and leave the input
// ready. A push runs the accept, one multiply-accumulate per tap on the
// shared MAC fed by registered reads of the tap and delay-line memories,
// and then pipeline drain and result load.
// Reset needs no memory sweep: a fill count masks delay-line slots not yet
// written since reset or clear. A waiting result holds in the output
// register; a later push stalls in drain until that word is taken.
// ---------------------------------------------------------------------------
`include "fir_linear_convolution_core_defines.svh"

module fir_linear_convolution_core import flc_pkg::*; #(
    parameter int MAX_TAPS = MAX_TAPS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    flc_in_if.sink    i_in_ch,
    flc_out_if.source o_out_ch,
    flc_cfg_if.sink   i_cfg_ch
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    assign i_cfg_ch.ready = 1'b1;

    flc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .i_in_cmd    (i_in_ch.cmd),
        .i_out_ready (o_out_ch.ready),
        .i_sts       (dp_sts),
        .o_in_ready  (i_in_ch.ready),
        .o_out_valid (o_out_ch.valid),
        .o_cmd       (dp_cmd)
    );

    flc_datapath #(
        .MAX_TAPS (MAX_TAPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_ch.valid),
        .i_cfg_data  (i_cfg_ch.data),
        .i_tap_index (i_in_ch.tap_index),
        .i_value     (i_in_ch.value),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_filtered  (o_out_ch.filtered)
    );

    `FLC_ASSERT_NXT(a_push_busy,
        i_in_ch.valid && i_in_ch.ready && (i_in_ch.cmd == CMD_PUSH),
        !i_in_ch.ready, "push did not start the tap sequence")
    `FLC_ASSERT_NXT(a_other_one_cycle,
        i_in_ch.valid && i_in_ch.ready && (i_in_ch.cmd != CMD_PUSH),
        i_in_ch.ready, "non-push word held the input")
    `FLC_ASSERT_IMP(a_idle_pipe_empty, i_in_ch.ready, !dp_sts.pipe_busy,
        "MAC pipeline busy while idle")

endmodule
